@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/kps_pkg.sv @@
`default_nettype none

package kps_pkg;

  // Grid geometry.
  localparam int GRID_SIDE = 6;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int NSYM      = 36;
  localparam int SYMW      = 6;
  localparam int CNTW      = 3;

  // Word kinds on the input channel.
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_MSG  = 2'd2;

  // Status codes on the output channel.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_KEY   = 2'd1;
  localparam logic [1:0] ST_BAD_DIGIT = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  // ASCII codes.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] LETTERS      = 8'd26;

  // A symbol lookup: ok is low for characters outside the alphabet.
  typedef struct packed {
    logic            ok;
    logic [SYMW-1:0] code;
  } sym_t;

  // Command to the shared add/subtract-by-six unit.
  typedef struct packed {
    logic            start;
    logic            mul;
    logic [SYMW-1:0] base;
    logic [CNTW-1:0] count;
  } six_op_t;

  // Result from the shared unit; acc and quot are valid while done is high.
  typedef struct packed {
    logic            done;
    logic [CNTW-1:0] quot;
    logic [SYMW-1:0] acc;
  } six_res_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) r = c - CASE_OFFSET;
    return r;
  endfunction

  function automatic sym_t sym_of(input logic [7:0] c);
    sym_t r;
    r.ok   = 1'b0;
    r.code = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.ok   = 1'b1;
      r.code = SYMW'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r.ok   = 1'b1;
      r.code = SYMW'(c - CHAR_ZERO + LETTERS);
    end
    return r;
  endfunction

  function automatic logic [7:0] ascii_of(input logic [SYMW-1:0] s);
    logic [7:0] r;
    if ({2'b00, s} < LETTERS) r = CHAR_UPPER_A + {2'b00, s};
    else r = CHAR_ZERO + ({2'b00, s} - LETTERS);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/kps_six_unit.sv @@
`default_nettype none

// Shared add/subtract-by-six unit. In divide mode it subtracts six until the
// remainder drops below six, counting the quotient. In multiply mode it adds
// six count times to the base, forming row * 6 + column.
module kps_six_unit (
  input  logic             clk,
  input  logic             rst,
  input  kps_pkg::six_op_t op,
  output kps_pkg::six_res_t res
);
  import kps_pkg::*;

  `include "assert_macros.svh"

  localparam logic [SYMW-1:0] STEP_UP   = SYMW'(GRID_SIDE);
  localparam logic [SYMW-1:0] STEP_DOWN = ~STEP_UP + SYMW'(1);

  logic            busy;
  logic            mul;
  logic [SYMW-1:0] acc;
  logic [CNTW-1:0] cnt;
  logic [CNTW-1:0] quot;
  logic [SYMW-1:0] sum;
  logic            finish;

  // One adder serves both directions.
  assign sum    = acc + (mul ? STEP_UP : STEP_DOWN);
  assign finish = mul ? (cnt == '0) : (acc < STEP_UP);

  assign res.done = busy && finish;
  assign res.quot = quot;
  assign res.acc  = acc;

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (op.start) begin
      busy <= 1'b1;
      mul  <= op.mul;
      acc  <= op.base;
      cnt  <= op.count;
      quot <= '0;
    end else if (busy) begin
      if (finish) begin
        busy <= 1'b0;
      end else begin
        acc <= sum;
        if (mul) cnt <= cnt - CNTW'(1);
        else quot <= quot + CNTW'(1);
      end
    end
  end

  `ASSERT_IMPLY(a_start_when_idle, clk, rst, op.start, !busy)
  `ASSERT_IMPLY(a_acc_in_grid, clk, rst, busy, acc < SYMW'(CELLS))
  `ASSERT_IMPLY(a_quot_in_side, clk, rst, busy && !mul, quot < CNTW'(GRID_SIDE))

endmodule

`default_nettype wire

@@ rtl/keyed_polybius_square_cipher.sv @@
`default_nettype none

// Channel  Signals                                Direction
// in       in_valid, in_ready, kind, in_char      words into the block
// out      out_valid, out_ready, out_char,        words out of the block
//          status, last
// cfg      cfg_valid, cfg_ready, cfg_data         encrypt_mode register write
//
// A word is taken only in the idle state; in_ready stays low while it is worked.
// Key character: placed in the decode state; a flagged one emits a status word.
// Encrypt: worked by the divide-by-six loop of the shared unit.
// Decrypt pair: worked by the multiply-by-six loop of the shared unit.
// Results wait in the output register while out_ready is low; the sequencer
// holds its next result until that register frees. Reset is synchronous.
// A register write is taken only in the idle state.
module keyed_polybius_square_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic [1:0] status,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import kps_pkg::*;

  `include "assert_macros.svh"

  localparam logic [SYMW-1:0] LAST_SYM  = SYMW'(NSYM - 1);
  localparam logic [SYMW-1:0] CELL_END  = SYMW'(CELLS);
  localparam logic [7:0]      DIGIT_END = CHAR_ZERO + 8'(GRID_SIDE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_READ,
    S_DIV,
    S_MUL,
    S_GREAD,
    S_EMIT
  } state_t;

  state_t          state;
  logic [1:0]      kind_q;
  logic [7:0]      char_q;
  logic            encrypt_mode;
  logic [NSYM-1:0] used_mask;
  logic [SYMW-1:0] fill_count;
  logic            grid_ready;
  logic [3:0]      pending_row;
  logic            row_pending;
  logic [SYMW-1:0] sym_cnt;
  logic [7:0]      res_char;
  logic [1:0]      res_status;
  logic            res_last;
  logic            has_second;
  logic [7:0]      second_char;

  // Grid stores.
  logic [SYMW-1:0] grid_symbol [CELLS];
  logic [SYMW-1:0] symbol_position [NSYM];
  logic [SYMW-1:0] pos_q;
  logic [SYMW-1:0] gsym_q;

  sym_t            sym;
  logic            clear_now;
  logic [NSYM-1:0] mask_eff;
  logic [SYMW-1:0] fill_eff;
  logic [NSYM-1:0] used_mask_next;
  logic [SYMW-1:0] fill_count_next;
  logic            place_req;
  logic [SYMW-1:0] place_sym;
  logic            place_en;
  logic            pos_rd;
  logic            grid_rd;
  logic            is_row_digit;
  logic [2:0]      digit;
  logic            slot_free;

  six_op_t         op;
  six_res_t        res;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  assign sym          = sym_of(char_q);
  assign is_row_digit = (char_q >= CHAR_ZERO) && (char_q < DIGIT_END);
  assign digit        = 3'(char_q - CHAR_ZERO);

  // A key character after a finished grid starts a new key from empty.
  assign clear_now = (state == S_DECODE) && (kind_q == KIND_KEY) && grid_ready;
  assign mask_eff  = clear_now ? '0 : used_mask;
  assign fill_eff  = clear_now ? '0 : fill_count;

  // Placement of one symbol into the next free cell.
  always_comb begin
    place_req = 1'b0;
    place_sym = sym_cnt;
    if (state == S_DECODE && kind_q == KIND_KEY && sym.ok) begin
      place_req = 1'b1;
      place_sym = sym.code;
    end else if (state == S_FILL) begin
      place_req = 1'b1;
    end
  end
  assign place_en = place_req && !mask_eff[place_sym] && (fill_eff < CELL_END);

  // Mask and count after this cycle's clear and placement.
  always_comb begin
    used_mask_next  = mask_eff;
    fill_count_next = fill_eff;
    if (place_en) begin
      used_mask_next[place_sym] = 1'b1;
      fill_count_next           = fill_eff + SYMW'(1);
    end
  end

  assign pos_rd  = (state == S_DECODE) && (kind_q == KIND_MSG) && grid_ready &&
                   encrypt_mode && (char_q != CHAR_SPACE) && sym.ok;
  assign grid_rd = (state == S_MUL) && res.done;

  // Grid memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (place_en) begin
      grid_symbol[fill_eff]      <= place_sym;
      symbol_position[place_sym] <= fill_eff;
    end
    if (pos_rd) pos_q <= symbol_position[sym.code];
    if (grid_rd) gsym_q <= grid_symbol[res.acc];
  end

  // Commands to the shared unit.
  always_comb begin
    op       = '0;
    op.base  = pos_q;
    if (state == S_READ) begin
      op.start = 1'b1;
    end else if (state == S_DECODE && kind_q == KIND_MSG && grid_ready &&
                 !encrypt_mode && char_q != CHAR_SPACE && is_row_digit && row_pending) begin
      op.start = 1'b1;
      op.mul   = 1'b1;
      op.base  = {3'b000, digit};
      op.count = pending_row[2:0];
    end
  end

  kps_six_unit u_six (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .res (res)
  );

  // Sequencer, grid bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      encrypt_mode <= 1'b1;
      used_mask    <= '0;
      fill_count   <= '0;
      grid_ready   <= 1'b0;
      pending_row  <= '0;
      row_pending  <= 1'b0;
      has_second   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // The emit state reloads the output register itself.
      if (out_ready && state != S_EMIT) out_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        encrypt_mode <= cfg_data;
        pending_row  <= '0;
        row_pending  <= 1'b0;
      end

      used_mask  <= used_mask_next;
      fill_count <= fill_count_next;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            char_q <= upcase(in_char);
            state  <= S_DECODE;
          end
        end

        S_DECODE: begin
          res_last   <= 1'b1;
          has_second <= 1'b0;
          case (kind_q)
            KIND_KEY: begin
              if (grid_ready) begin
                grid_ready  <= 1'b0;
                pending_row <= '0;
                row_pending <= 1'b0;
              end
              if (!sym.ok) begin
                res_char   <= '0;
                res_status <= ST_BAD_KEY;
                state      <= S_EMIT;
              end else begin
                state <= S_IDLE;
              end
            end
            KIND_DONE: begin
              if (!grid_ready) begin
                sym_cnt <= '0;
                state   <= S_FILL;
              end else begin
                state <= S_IDLE;
              end
            end
            KIND_MSG: begin
              if (!grid_ready) begin
                res_char   <= '0;
                res_status <= ST_NOT_READY;
                state      <= S_EMIT;
              end else if (encrypt_mode) begin
                if (char_q == CHAR_SPACE) begin
                  res_char   <= CHAR_SPACE;
                  res_status <= ST_OK;
                  state      <= S_EMIT;
                end else if (sym.ok) begin
                  state <= S_READ;
                end else begin
                  state <= S_IDLE;
                end
              end else if (char_q == CHAR_SPACE) begin
                res_char    <= CHAR_SPACE;
                res_status  <= row_pending ? ST_BAD_DIGIT : ST_OK;
                pending_row <= '0;
                row_pending <= 1'b0;
                state       <= S_EMIT;
              end else if (is_row_digit) begin
                if (!row_pending) begin
                  pending_row <= {1'b0, digit};
                  row_pending <= 1'b1;
                  state       <= S_IDLE;
                end else begin
                  pending_row <= '0;
                  row_pending <= 1'b0;
                  state       <= S_MUL;
                end
              end else begin
                pending_row <= '0;
                row_pending <= 1'b0;
                res_char    <= '0;
                res_status  <= ST_BAD_DIGIT;
                state       <= S_EMIT;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        // Append the unused alphabet, one symbol per cycle.
        S_FILL: begin
          sym_cnt <= sym_cnt + SYMW'(1);
          if (sym_cnt == LAST_SYM) begin
            grid_ready  <= 1'b1;
            pending_row <= '0;
            row_pending <= 1'b0;
            state       <= S_IDLE;
          end
        end

        // Position read is in pos_q; the unit is started here.
        S_READ: begin
          state <= S_DIV;
        end

        S_DIV: begin
          if (res.done) begin
            res_char    <= CHAR_ZERO + {5'b00000, res.quot};
            second_char <= CHAR_ZERO + {2'b00, res.acc};
            res_status  <= ST_OK;
            res_last    <= 1'b0;
            has_second  <= 1'b1;
            state       <= S_EMIT;
          end
        end

        S_MUL: begin
          if (res.done) state <= S_GREAD;
        end

        S_GREAD: begin
          res_char   <= ascii_of(gsym_q);
          res_status <= ST_OK;
          res_last   <= 1'b1;
          state      <= S_EMIT;
        end

        // Hand the pending word to the output register when it frees.
        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= res_char;
            status    <= res_status;
            last      <= res_last;
            if (has_second) begin
              res_char   <= second_char;
              res_last   <= 1'b1;
              has_second <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_fill_matches_mask, clk, rst, 1'b1, SYMW'($countones(used_mask)) == fill_count)
  `ASSERT_IMPLY(a_ready_grid_full, clk, rst, grid_ready, fill_count == CELL_END)
  `ASSERT_IMPLY(a_pending_row_range, clk, rst, row_pending, pending_row < 4'(GRID_SIDE))
  `ASSERT_NEXT(a_fill_sets_ready, clk, rst, state == S_FILL && sym_cnt == LAST_SYM, grid_ready)

endmodule

`default_nettype wire
